// ===== rtl/core/qvr_pkg.sv =====
// qvr_pkg: shared constants for the quaternion vector rotation pipeline
// no dependencies

package qvr_pkg;

  localparam int AXES   = 3;
  localparam int QCOMPS = 4;

  localparam int QI = 0;
  localparam int QJ = 1;
  localparam int QK = 2;
  localparam int QR = 3;

endpackage

// ===== rtl/core/qvr_div.sv =====
// qvr_div: pipelined restoring divider, one quotient bit per stage
// gives floor(a2 * 4^(QW-1) / sumsq); no package needed

module qvr_div #(
  parameter int QW = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic [2*QW-2:0]   a2,
  input  logic [2*QW:0]     sumsq,
  output logic [2*QW-2:0]   quo
);

  localparam int QB = 2 * QW - 1;
  localparam int RW = 2 * QW + 2;

  logic [RW-1:0]   rem   [QB+1];
  logic [QB-1:0]   quo_s [QB+1];
  logic [2*QW:0]   den   [QB+1];

  assign rem[0]   = RW'(a2 >> 1);
  assign quo_s[0] = '0;
  assign den[0]   = sumsq;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic          fb;
    logic [RW-1:0] sh;
    logic [RW-1:0] diff;

    if (k == 0) begin : g_first
      assign fb = a2[0];
    end else begin : g_rest
      assign fb = 1'b0;
    end

    assign sh   = {rem[k][RW-2:0], fb};
    assign diff = sh - RW'(den[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        den[k+1] <= den[k];
        if (sh >= RW'(den[k])) begin
          rem[k+1]   <= diff;
          quo_s[k+1] <= {quo_s[k][QB-2:0], 1'b1};
        end else begin
          rem[k+1]   <= sh;
          quo_s[k+1] <= {quo_s[k][QB-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_s[QB];

endmodule

// ===== rtl/core/qvr_sqrt.sv =====
// qvr_sqrt: pipelined integer square root, one root bit per stage
// gives floor(sqrt(x)); no package needed

module qvr_sqrt #(
  parameter int QW = 16
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*QW-2:0] x,
  output logic [QW-1:0]   root
);

  localparam int RW = QW + 3;

  logic [2*QW-1:0] xs     [QW+1];
  logic [RW-1:0]   rem    [QW+1];
  logic [QW-1:0]   root_s [QW+1];

  assign xs[0]     = {1'b0, x};
  assign rem[0]    = '0;
  assign root_s[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [1:0]    pair;
    logic [RW-1:0] sh;
    logic [RW-1:0] trial;

    assign pair  = xs[k][2*(QW-1-k) +: 2];
    assign sh    = {rem[k][RW-3:0], pair};
    assign trial = RW'({root_s[k], 2'b01});

    always_ff @(posedge clk) begin
      if (en) begin
        xs[k+1] <= xs[k];
        if (sh >= trial) begin
          rem[k+1]    <= sh - trial;
          root_s[k+1] <= {root_s[k][QW-2:0], 1'b1};
        end else begin
          rem[k+1]    <= sh;
          root_s[k+1] <= {root_s[k][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign root = root_s[QW];

endmodule

// ===== rtl/core/qvr_norm.sv =====
// qvr_norm: quaternion normalisation, squares, sum, divide and square root per component
// uses qvr_pkg, qvr_div and qvr_sqrt

module qvr_norm import qvr_pkg::*; #(
  parameter int VW = 32,
  parameter int QW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [VW-1:0] vec_in [AXES],
  input  logic signed [QW-1:0] quat_in [QCOMPS],
  output logic                 u_valid,
  output logic signed [QW-1:0] u [QCOMPS],
  output logic signed [VW-1:0] vec_out [AXES]
);

  localparam int QB = 2 * QW - 1;
  localparam int DL = QB + QW;
  localparam int SW = QCOMPS + 1 + AXES * VW;
  localparam logic signed [QW-1:0] UNIT = QW'(1 << (QW - 2));

  logic                 s1_valid;
  logic signed [QW-1:0] q1 [QCOMPS];
  logic [2*QW-2:0]      sq1 [QCOMPS];
  logic [VW-1:0]        vec1 [AXES];

  logic                 s2_valid;
  logic [2*QW:0]        sum2;
  logic [2*QW-2:0]      a2_2 [QCOMPS];
  logic [QCOMPS-1:0]    neg2;
  logic [AXES*VW-1:0]   vec2;

  logic [DL:0]          vld_d;
  logic [SW-1:0]        side_d [DL+1];
  logic [2*QW-2:0]      quo [QCOMPS];
  logic [QW-1:0]        root [QCOMPS];

  logic [QCOMPS-1:0]    neg_f;
  logic                 zero_f;
  logic [AXES*VW-1:0]   vec_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QCOMPS; i++) begin
        q1[i]   <= quat_in[i];
        sq1[i]  <= (2*QW-1)'(quat_in[i] * quat_in[i]);
        a2_2[i] <= sq1[i];
        neg2[i] <= q1[i][QW-1];
      end
      for (int i = 0; i < AXES; i++) begin
        vec1[i] <= vec_in[i];
      end
      vec2 <= {vec1[QR-1], vec1[QJ], vec1[QI]};
      sum2 <= (2*QW+1)'(sq1[QI]) + (2*QW+1)'(sq1[QJ])
            + (2*QW+1)'(sq1[QK]) + (2*QW+1)'(sq1[QR]);
    end
  end

  for (genvar i = 0; i < QCOMPS; i++) begin : g_comp
    qvr_div #(.QW(QW)) u_div (
      .clk   (clk),
      .en    (en),
      .a2    (a2_2[i]),
      .sumsq (sum2),
      .quo   (quo[i])
    );
    qvr_sqrt #(.QW(QW)) u_sqrt (
      .clk  (clk),
      .en   (en),
      .x    (quo[i]),
      .root (root[i])
    );
  end

  assign vld_d[0]  = s2_valid;
  assign side_d[0] = {neg2, (sum2 == '0), vec2};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_d[DL:1] <= '0;
    end else if (en) begin
      vld_d[DL:1] <= vld_d[DL-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DL; k++) begin
        side_d[k+1] <= side_d[k];
      end
    end
  end

  assign {neg_f, zero_f, vec_f} = side_d[DL];

  always_ff @(posedge clk) begin
    if (rst) begin
      u_valid <= 1'b0;
    end else if (en) begin
      u_valid <= vld_d[DL];
    end
  end

  always_ff @(posedge clk) begin
    logic [QW:0]   rp1;
    logic [QW-1:0] m;
    if (en) begin
      for (int i = 0; i < QCOMPS; i++) begin
        rp1 = {1'b0, root[i]} + (QW+1)'(1);
        m   = rp1[QW:1];
        if (zero_f) begin
          u[i] <= (i == QR) ? UNIT : '0;
        end else if (neg_f[i]) begin
          u[i] <= -$signed(m);
        end else begin
          u[i] <= $signed(m);
        end
      end
      for (int i = 0; i < AXES; i++) begin
        vec_out[i] <= vec_f[i*VW +: VW];
      end
    end
  end

  a_unit_range : assert property (@(posedge clk) disable iff (rst)
    u_valid |-> (u[QI] <= UNIT && u[QI] >= -UNIT && u[QJ] <= UNIT && u[QJ] >= -UNIT
              && u[QK] <= UNIT && u[QK] >= -UNIT && u[QR] <= UNIT && u[QR] >= -UNIT))
    else $error("normalised component above one");

endmodule

// ===== rtl/core/qvr_rotate.sv =====
// qvr_rotate: rotation matrix from unit quaternion, matrix-vector product, rounding, saturation
// uses qvr_pkg

module qvr_rotate import qvr_pkg::*; #(
  parameter int VW = 32,
  parameter int QW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [QW-1:0] u [QCOMPS],
  input  logic signed [VW-1:0] vec [AXES],
  output logic                 out_valid,
  output logic signed [VW-1:0] rot [AXES],
  output logic                 clipped
);

  localparam int PW = 2 * QW;
  localparam int EW = 2 * QW + 3;
  localparam int MW = 2 * QW;
  localparam int XW = MW + VW;
  localparam int SW = XW + 2;
  localparam int SH = 2 * QW - 4;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (SH - 1);
  localparam logic signed [SW-1:0] MAXV = SW'((65'(1) << (VW - 1)) - 65'(1));
  localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

  logic                 v1, v2, v3, v4;
  logic signed [PW-1:0] xx, yy, zz, ss, xy, xz, yz, sx, sy, sz;
  logic signed [VW-1:0] vec1 [AXES];
  logic signed [VW-1:0] vec2 [AXES];
  logic signed [MW-1:0] mat2 [AXES*AXES];
  logic signed [XW-1:0] pr3 [AXES*AXES];
  logic signed [SW-1:0] row4 [AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx <= u[QI] * u[QI];
      yy <= u[QJ] * u[QJ];
      zz <= u[QK] * u[QK];
      ss <= u[QR] * u[QR];
      xy <= u[QI] * u[QJ];
      xz <= u[QI] * u[QK];
      yz <= u[QJ] * u[QK];
      sx <= u[QR] * u[QI];
      sy <= u[QR] * u[QJ];
      sz <= u[QR] * u[QK];
      vec1 <= vec;
      vec2 <= vec1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat2[0] <= MW'(EW'(ss) + EW'(xx) - EW'(yy) - EW'(zz));
      mat2[1] <= MW'((EW'(xy) - EW'(sz)) <<< 1);
      mat2[2] <= MW'((EW'(xz) + EW'(sy)) <<< 1);
      mat2[3] <= MW'((EW'(xy) + EW'(sz)) <<< 1);
      mat2[4] <= MW'(EW'(ss) - EW'(xx) + EW'(yy) - EW'(zz));
      mat2[5] <= MW'((EW'(yz) - EW'(sx)) <<< 1);
      mat2[6] <= MW'((EW'(xz) - EW'(sy)) <<< 1);
      mat2[7] <= MW'((EW'(yz) + EW'(sx)) <<< 1);
      mat2[8] <= MW'(EW'(ss) - EW'(xx) - EW'(yy) + EW'(zz));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < AXES; r++) begin
        for (int c = 0; c < AXES; c++) begin
          pr3[r*AXES+c] <= mat2[r*AXES+c] * vec2[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < AXES; r++) begin
        row4[r] <= SW'(pr3[r*AXES]) + SW'(pr3[r*AXES+1]) + SW'(pr3[r*AXES+2]) + HALF;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [SW-1:0] sr;
    logic                 clip;
    if (en) begin
      clip = 1'b0;
      for (int r = 0; r < AXES; r++) begin
        sr = row4[r] >>> SH;
        if (sr > MAXV) begin
          rot[r] <= VW'(MAXV);
          clip = 1'b1;
        end else if (sr < MINV) begin
          rot[r] <= VW'(MINV);
          clip = 1'b1;
        end else begin
          rot[r] <= VW'(sr);
        end
      end
      clipped <= clip;
    end
  end

endmodule

// ===== rtl/core/quaternion_vector_rotate_unit.sv =====
// Rotates a Q16.16 vector by a Q2.14 quaternion that is normalised on the fly, one word per
// clock while out_stall does not hold the output. The bit-per-stage divider and square root of
// the normalisation make up most of the pipeline depth. A zero quaternion acts as the identity.
// Results are rounded to nearest and saturated, with clipped set when any component hit a
// limit. out_stall freezes the whole pipeline.
// uses qvr_pkg, qvr_norm, qvr_rotate

module quaternion_vector_rotate_unit import qvr_pkg::*; #(
  parameter int VECTOR_WIDTH = 32,
  parameter int QUAT_WIDTH   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [VECTOR_WIDTH-1:0] vec_x,
  input  logic signed [VECTOR_WIDTH-1:0] vec_y,
  input  logic signed [VECTOR_WIDTH-1:0] vec_z,
  input  logic signed [QUAT_WIDTH-1:0]   quat_i,
  input  logic signed [QUAT_WIDTH-1:0]   quat_j,
  input  logic signed [QUAT_WIDTH-1:0]   quat_k,
  input  logic signed [QUAT_WIDTH-1:0]   quat_real,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [VECTOR_WIDTH-1:0] rot_x,
  output logic signed [VECTOR_WIDTH-1:0] rot_y,
  output logic signed [VECTOR_WIDTH-1:0] rot_z,
  output logic                           clipped
);

  localparam logic signed [VECTOR_WIDTH-1:0] VMAX =
    VECTOR_WIDTH'((65'(1) << (VECTOR_WIDTH - 1)) - 65'(1));
  localparam logic signed [VECTOR_WIDTH-1:0] VMIN = -VMAX - VECTOR_WIDTH'(1);

  logic                           en;
  logic signed [VECTOR_WIDTH-1:0] vec_in [AXES];
  logic signed [QUAT_WIDTH-1:0]   quat_in [QCOMPS];
  logic                           u_valid;
  logic signed [QUAT_WIDTH-1:0]   u [QCOMPS];
  logic signed [VECTOR_WIDTH-1:0] vec_n [AXES];
  logic signed [VECTOR_WIDTH-1:0] rot [AXES];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign vec_in[0]   = vec_x;
  assign vec_in[1]   = vec_y;
  assign vec_in[2]   = vec_z;
  assign quat_in[QI] = quat_i;
  assign quat_in[QJ] = quat_j;
  assign quat_in[QK] = quat_k;
  assign quat_in[QR] = quat_real;

  qvr_norm #(.VW(VECTOR_WIDTH), .QW(QUAT_WIDTH)) u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .vec_in   (vec_in),
    .quat_in  (quat_in),
    .u_valid  (u_valid),
    .u        (u),
    .vec_out  (vec_n)
  );

  qvr_rotate #(.VW(VECTOR_WIDTH), .QW(QUAT_WIDTH)) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (u_valid),
    .u         (u),
    .vec       (vec_n),
    .out_valid (out_valid),
    .rot       (rot),
    .clipped   (clipped)
  );

  assign rot_x = rot[0];
  assign rot_y = rot[1];
  assign rot_z = rot[2];

  a_clip_at_limit : assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> (rot_x == VMAX || rot_x == VMIN || rot_y == VMAX
                           || rot_y == VMIN || rot_z == VMAX || rot_z == VMIN))
    else $error("clipped without a component at a limit");

  a_empty_takes : assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input held with empty output");

  a_stall_holds : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(clipped))
    else $error("stalled word lost");

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for quaternion_vector_rotate_unit, with a bit-exact predictor,
// a scoreboard class, random idling on both channels and one long output hold-off
// depends on qvr_pkg and the rtl of quaternion_vector_rotate_unit
`timescale 1ns / 1ps

module tb;
  import qvr_pkg::*;

  localparam int VW = 32;
  localparam int QW = 16;
  localparam int QF = QW - 2;
  localparam int ITEMS = 900;
  localparam int LIMIT = 400000;

  typedef struct {
    logic signed [VW-1:0] x, y, z;
    logic                 clip;
  } rot_word_t;

  class rotation_board;
    rot_word_t pending[$];
    int        errors = 0;

    function automatic longint norm_comp(longint c, longint sumsq);
      logic [127:0] rhs, lhs;
      longint a, lo, hi, m, t;
      a = c < 0 ? -c : c;
      rhs = 128'(a * a) << (2 * QF + 2);
      lo = 0;
      hi = longint'(1) << QF;
      while (lo < hi) begin
        m = (lo + hi + 1) >> 1;
        t = 2 * m - 1;
        lhs = 128'(t * t) * 128'(sumsq);
        if (lhs <= rhs) lo = m;
        else hi = m - 1;
      end
      return c < 0 ? -lo : lo;
    endfunction

    function automatic logic signed [VW-1:0] row(longint m0, longint m1, longint m2,
                                                 longint v[AXES], inout logic clip);
      logic signed [127:0] acc, a0, a1, a2, b0, b1, b2, maxv, minv;
      a0 = m0; a1 = m1; a2 = m2;
      b0 = v[0]; b1 = v[1]; b2 = v[2];
      maxv = (128'sd1 <<< (VW - 1)) - 1;
      minv = -maxv - 1;
      acc = a0 * b0 + a1 * b1 + a2 * b2 + (128'sd1 <<< (2 * QF - 1));
      acc = acc >>> (2 * QF);
      if (acc > maxv) begin
        clip = 1'b1;
        acc = maxv;
      end
      if (acc < minv) begin
        clip = 1'b1;
        acc = minv;
      end
      return acc[VW-1:0];
    endfunction

    function void note(logic signed [VW-1:0] vx, vy, vz, logic signed [QW-1:0] qv[QCOMPS]);
      longint v[AXES];
      longint q[QCOMPS];
      longint sumsq, ux, uy, uz, s;
      longint xx, yy, zz, ss, xy, xz, yz, sx, sy, sz;
      rot_word_t w;
      v[0] = vx; v[1] = vy; v[2] = vz;
      sumsq = 0;
      for (int i = 0; i < QCOMPS; i++) begin
        q[i] = qv[i];
        sumsq += q[i] * q[i];
      end
      if (sumsq == 0) begin
        ux = 0; uy = 0; uz = 0; s = longint'(1) << QF;
      end else begin
        ux = norm_comp(q[QI], sumsq);
        uy = norm_comp(q[QJ], sumsq);
        uz = norm_comp(q[QK], sumsq);
        s  = norm_comp(q[QR], sumsq);
      end
      xx = ux * ux; yy = uy * uy; zz = uz * uz; ss = s * s;
      xy = ux * uy; xz = ux * uz; yz = uy * uz;
      sx = s * ux; sy = s * uy; sz = s * uz;
      w.clip = 1'b0;
      w.x = row(ss + xx - yy - zz, 2 * (xy - sz), 2 * (xz + sy), v, w.clip);
      w.y = row(2 * (xy + sz), ss - xx + yy - zz, 2 * (yz - sx), v, w.clip);
      w.z = row(2 * (xz - sy), 2 * (yz + sx), ss - xx - yy + zz, v, w.clip);
      pending.push_back(w);
    endfunction

    function void check(rot_word_t got);
      rot_word_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time, got.x, got.y, got.z);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.x !== e.x) begin
        $display("%0t: rot_x expected %0d actual %0d", $time, e.x, got.x);
        errors++;
      end
      if (got.y !== e.y) begin
        $display("%0t: rot_y expected %0d actual %0d", $time, e.y, got.y);
        errors++;
      end
      if (got.z !== e.z) begin
        $display("%0t: rot_z expected %0d actual %0d", $time, e.z, got.z);
        errors++;
      end
      if (got.clip !== e.clip) begin
        $display("%0t: clipped expected %0b actual %0b", $time, e.clip, got.clip);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [VW-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic signed [QW-1:0] quat_i = '0, quat_j = '0, quat_k = '0, quat_real = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VW-1:0] rot_x, rot_y, rot_z;
  logic clipped;

  rotation_board board = new();
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  held = 1'b0;

  always #2 clk = ~clk;

  quaternion_vector_rotate_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .quat_i(quat_i), .quat_j(quat_j), .quat_k(quat_k), .quat_real(quat_real),
    .out_valid(out_valid), .out_stall(out_stall),
    .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .clipped(clipped)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("quaternion_vector_rotate_unit regression: fail");
      $finish;
    end
  end

  // result side
  always @(posedge clk) begin
    rot_word_t got;
    if (!rst && out_valid && !out_stall) begin
      got.x = rot_x;
      got.y = rot_y;
      got.z = rot_z;
      got.clip = clipped;
      board.check(got);
    end
  end

  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!quiet && !held && cycles > 300) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 7);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  task automatic send(logic signed [VW-1:0] vx, vy, vz, logic signed [QW-1:0] qi, qj, qk, qr);
    logic signed [QW-1:0] qv[QCOMPS];
    int gap;
    vec_x <= vx; vec_y <= vy; vec_z <= vz;
    quat_i <= qi; quat_j <= qj; quat_k <= qk; quat_real <= qr;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    qv[QI] = qi; qv[QJ] = qj; qv[QK] = qk; qv[QR] = qr;
    board.note(vx, vy, vz, qv);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [VW-1:0] rand_vec();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0fff_ffff)) - 32'sh0800_0000;
      2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
    endcase
  endfunction

  function automatic logic signed [QW-1:0] rand_quat(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(0, 16'h7fff))) - 16'sh4000;
      2: return $signed(16'($urandom_range(0, 7))) - 16'sd3;
      default: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  initial begin
    int m;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words
    send(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send(32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 16'sd0, 16'sd0, 16'sd0, 16'sh4000);
    send(32'sh0001_0000, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sh2d41, 16'sh2d41);
    send(32'sh0001_0000, 32'sh0001_0000, 32'sd0, 16'sh4000, 16'sd0, 16'sd0, 16'sd0);
    send(32'sh0000_8000, -32'sh0000_8000, 32'sh1234, 16'sd0, 16'sh4000, 16'sd0, 16'sd0);
    send(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sd0, 16'sd0, 16'sd0, 16'sh2000, 16'sh2000);
    send(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 16'sh2000, 16'sh2000, 16'sh2000,
         16'sh2000);
    send(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
         16'sh7fff);
    send(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 16'sh8000, 16'sh8000, 16'sh8000,
         16'sh8000);
    send(-32'sd1, 32'sd1, -32'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0);
    send(32'sd3, -32'sd5, 32'sd7, 16'sd1, -16'sd1, 16'sd1, 16'sd1);
    send(32'sh0100_0000, 32'sh0200_0000, 32'sh0300_0000, 16'sd3, 16'sd4, 16'sd0, 16'sd0);
    send(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0001, 16'sh8000, 16'sd0, 16'sd0, 16'sd1);
    send(32'sh4000_0000, -32'sh4000_0000, 32'sh4000_0000, 16'sh1000, -16'sh1000, 16'sh1000,
         16'sh6000);
    send(32'sh0123_4567, 32'sh89ab_cdef, 32'sh7654_3210, 16'sh0001, 16'sh0001, 16'sh0001,
         16'sh0001);

    for (int i = 0; i < ITEMS; i++) begin
      if (i > ITEMS - 120) quiet = 1'b1;
      m = $urandom_range(0, 9);
      if (m == 0)
        send(rand_vec(), rand_vec(), rand_vec(), 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      else
        send(rand_vec(), rand_vec(), rand_vec(), rand_quat(m % 4), rand_quat((m + 1) % 4),
             rand_quat(m % 3), rand_quat((m * 7) % 4));
    end
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (board.errors == 0)
      $display("quaternion_vector_rotate_unit regression: pass");
    else
      $display("quaternion_vector_rotate_unit regression: fail");
    $finish;
  end

endmodule
